/* hw/rtl/ft2_pkg.sv */
// ----------------------------------------------------------------------------
// ft2_pkg: shared types and constants of the 2-D Fenwick tree sum block
// Request codes, register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ft2_pkg;

  localparam int unsigned MAX_ROWS_DEF  = 64;
  localparam int unsigned MAX_COLS_DEF  = 64;
  localparam int unsigned SUM_WIDTH_DEF = 32;

  localparam int unsigned IDX_W     = 6;   // request row/column index
  localparam int unsigned CNT_W     = 7;   // rows/cols in use register
  localparam int unsigned VAL_W     = 32;  // add value
  localparam int unsigned RES_W     = 32;  // sum result
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_RECT   = 2'd1,
    ACT_SUFFIX = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_SETUP,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;       // capture request, clear accumulator
    logic clr_step;   // write one zero entry of the clearing sweep
    logic walk_init;  // load walk start for current prefix
    logic walk_step;  // issue one tree read and advance the walk
    logic pfx_next;   // advance to next prefix term
  } ft2_cmd_t;

  typedef struct packed {
    action_e action;
    logic    bad;
    logic    clr_last;
    logic    walk_act;
    logic    pfx_last;
  } ft2_stat_t;

endpackage

/* hw/rtl/ft2_ctrl.sv */
// ----------------------------------------------------------------------------
// ft2_ctrl: request sequencer
// Steps the datapath through clearing sweeps, point-add walks and the four
// prefix walks of a rectangle or suffix sum.
// ----------------------------------------------------------------------------
module ft2_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                done_o,
  input  ft2_pkg::ft2_stat_t  stat_i,
  output ft2_pkg::ft2_cmd_t   cmd_o
);
  import ft2_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat_i.bad) begin
          state_d = ST_DONE;
        end else if (stat_i.action == ACT_CLEAR) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_SETUP;
        end
      end
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_DONE;
      end
      ST_SETUP: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (!stat_i.walk_act) begin
          if (stat_i.action == ACT_ADD || stat_i.pfx_last) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_INIT:   cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_DECODE: ;
      ST_CLEAR:  cmd_o.clr_step = 1'b1;
      ST_SETUP:  cmd_o.walk_init = 1'b1;
      ST_WALK: begin
        cmd_o.walk_step = stat_i.walk_act;
        cmd_o.pfx_next  = !stat_i.walk_act && stat_i.action != ACT_ADD && !stat_i.pfx_last;
      end
      ST_DONE:   done_o = 1'b1;
      default:   busy_o = 1'b1;
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.clr_step, cmd_o.walk_init, cmd_o.walk_step, cmd_o.pfx_next}))
    else $error("ft2_ctrl: more than one datapath command");

  a_start_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_DECODE))
    else $error("ft2_ctrl: accepted request not decoded");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == ST_IDLE))
    else $error("ft2_ctrl: result strobe not followed by idle");

endmodule

/* hw/rtl/ft2_dp.sv */
// ----------------------------------------------------------------------------
// ft2_dp: tree memory, index walker and accumulator
// Holds the configuration registers, the request fields, the tree memory with
// its clearing sweep counter and a one-read-per-cycle Fenwick index walker.
// ----------------------------------------------------------------------------
module ft2_dp #(
  parameter int unsigned MAX_ROWS  = ft2_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS  = ft2_pkg::MAX_COLS_DEF,
  parameter int unsigned SUM_WIDTH = ft2_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic        [ft2_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [ft2_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic        [1:0]                    action_i,
  input  logic        [ft2_pkg::IDX_W-1:0]     row_lo_i,
  input  logic        [ft2_pkg::IDX_W-1:0]     col_lo_i,
  input  logic        [ft2_pkg::IDX_W-1:0]     row_hi_i,
  input  logic        [ft2_pkg::IDX_W-1:0]     col_hi_i,
  input  logic signed [ft2_pkg::VAL_W-1:0]     add_value_i,
  input  ft2_pkg::ft2_cmd_t                    cmd_i,
  output ft2_pkg::ft2_stat_t                   stat_o,
  output logic signed [ft2_pkg::RES_W-1:0]     sum_result_o,
  output logic                                 status_o
);
  import ft2_pkg::*;

  localparam int unsigned RB    = $clog2(MAX_ROWS);
  localparam int unsigned CB    = $clog2(MAX_COLS);
  localparam int unsigned AW    = RB + CB;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned RIW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CIW   = $clog2(MAX_COLS + 1);
  localparam int unsigned EW0   = (RIW > CIW) ? RIW : CIW;
  localparam int unsigned EW    = (EW0 > CNT_W) ? EW0 : CNT_W;

  localparam logic [EW-1:0]  MAXR_E = EW'(MAX_ROWS);
  localparam logic [EW-1:0]  MAXC_E = EW'(MAX_COLS);
  localparam logic [RIW:0]   MAXR_W = (RIW + 1)'(MAX_ROWS);
  localparam logic [CIW:0]   MAXC_W = (CIW + 1)'(MAX_COLS);

  // Configuration registers
  logic [CNT_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CNT_RESET;
      cols_q <= CNT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ROWS) rows_q <= cfg_data_i;
      if (cfg_index_i == CFG_COLS) cols_q <= cfg_data_i;
    end
  end

  // Request decode: effective counts, bounds check, walk corners
  logic [EW-1:0]  rows_e, cols_e, nr, nc, r1, c1, r2, c2;
  logic           bad_d;
  logic [RIW-1:0] row_hi_d;
  logic [CIW-1:0] col_hi_d;
  action_e        action_in;

  always_comb begin
    action_in = action_e'(action_i);
    rows_e    = EW'(rows_q);
    cols_e    = EW'(cols_q);
    nr        = (rows_e > MAXR_E) ? MAXR_E : rows_e;
    nc        = (cols_e > MAXC_E) ? MAXC_E : cols_e;
    r1        = EW'(row_lo_i);
    c1        = EW'(col_lo_i);
    r2        = EW'(row_hi_i);
    c2        = EW'(col_hi_i);
    bad_d     = 1'b0;
    row_hi_d  = RIW'(nr);
    col_hi_d  = CIW'(nc);
    case (action_in)
      ACT_ADD: begin
        bad_d    = !(r1 < nr && c1 < nc);
        row_hi_d = RIW'(r1 + EW'(1));
        col_hi_d = CIW'(c1 + EW'(1));
      end
      ACT_RECT: begin
        bad_d    = !(r1 <= r2 && c1 <= c2 && r2 < nr && c2 < nc);
        row_hi_d = RIW'(r2 + EW'(1));
        col_hi_d = CIW'(c2 + EW'(1));
      end
      ACT_SUFFIX: begin
        bad_d = !(r1 < nr && c1 < nc);
      end
      default: bad_d = 1'b0;
    endcase
  end

  logic [SUM_WIDTH-1:0] val_d;

  if (SUM_WIDTH <= VAL_W) begin : g_val_trunc
    assign val_d = add_value_i[SUM_WIDTH-1:0];
  end else begin : g_val_ext
    assign val_d = {{(SUM_WIDTH - VAL_W){add_value_i[VAL_W-1]}}, add_value_i};
  end

  // Request registers
  action_e              action_q;
  logic                 bad_q;
  logic [RIW-1:0]       row_hi_q, row_lo_q;
  logic [CIW-1:0]       col_hi_q, col_lo_q;
  logic [SUM_WIDTH-1:0] val_q;
  logic [1:0]           pfx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q <= ACT_ADD;
      bad_q    <= 1'b0;
      pfx_q    <= '0;
    end else if (cmd_i.load) begin
      action_q <= action_in;
      bad_q    <= bad_d;
      pfx_q    <= '0;
    end else if (cmd_i.pfx_next) begin
      pfx_q <= pfx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_hi_q <= row_hi_d;
      col_hi_q <= col_hi_d;
      row_lo_q <= RIW'(r1);
      col_lo_q <= CIW'(c1);
      val_q    <= val_d;
    end
  end

  // Fenwick index walker: down for prefix sums, up for point adds
  logic           up;
  logic [RIW-1:0] i_q, i0, li, id;
  logic [CIW-1:0] j_q, js_q, j0, lj, jd;
  logic [RIW:0]   iu;
  logic [CIW:0]   ju;
  logic           j_wrap;
  logic           walk_act_q, sign_q;

  always_comb begin
    up     = (action_q == ACT_ADD);
    i0     = pfx_q[1] ? row_lo_q : row_hi_q;
    j0     = pfx_q[0] ? col_lo_q : col_hi_q;
    li     = i_q & (~i_q + RIW'(1));
    lj     = j_q & (~j_q + CIW'(1));
    id     = i_q - li;
    jd     = j_q - lj;
    iu     = {1'b0, i_q} + {1'b0, li};
    ju     = {1'b0, j_q} + {1'b0, lj};
    j_wrap = up ? (ju > MAXC_W) : (jd == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_act_q <= 1'b0;
    end else if (cmd_i.walk_init) begin
      walk_act_q <= up || (i0 != '0 && j0 != '0);
    end else if (cmd_i.walk_step && walk_act_q && j_wrap) begin
      walk_act_q <= up ? (iu <= MAXR_W) : (id != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      i_q    <= i0;
      j_q    <= j0;
      js_q   <= j0;
      sign_q <= ^pfx_q;
    end else if (cmd_i.walk_step && walk_act_q) begin
      if (j_wrap) begin
        j_q <= js_q;
        i_q <= up ? RIW'(iu) : id;
      end else begin
        j_q <= up ? CIW'(ju) : jd;
      end
    end
  end

  // Tree memory: one write port, one registered read port
  logic [SUM_WIDTH-1:0] mem_q [DEPTH];
  logic [SUM_WIDTH-1:0] rdata_q, mem_wdata;
  logic [AW-1:0]        cell_addr, waddr_q, clr_addr_q, mem_waddr;
  logic                 rd_vld_q, rd_sign_q, mem_we;
  logic [SUM_WIDTH-1:0] acc_q;

  assign cell_addr = {RB'(i_q - RIW'(1)), CB'(j_q - CIW'(1))};
  assign mem_we    = cmd_i.clr_step || (rd_vld_q && up);
  assign mem_waddr = cmd_i.clr_step ? clr_addr_q : waddr_q;
  assign mem_wdata = cmd_i.clr_step ? '0 : (rdata_q + val_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[cell_addr];
  end

  always_ff @(posedge clk_i) begin
    waddr_q   <= cell_addr;
    rd_sign_q <= sign_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      clr_addr_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.walk_step && walk_act_q;
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // Accumulate prefix terms with their signs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.load) begin
      acc_q <= '0;
    end else if (rd_vld_q && !up) begin
      acc_q <= rd_sign_q ? (acc_q - rdata_q) : (acc_q + rdata_q);
    end
  end

  if (SUM_WIDTH >= RES_W) begin : g_res_trunc
    assign sum_result_o = acc_q[RES_W-1:0];
  end else begin : g_res_ext
    assign sum_result_o = {{(RES_W - SUM_WIDTH){1'b0}}, acc_q};
  end

  assign status_o        = bad_q;
  assign stat_o.action   = action_q;
  assign stat_o.bad      = bad_q;
  assign stat_o.clr_last = &clr_addr_q;
  assign stat_o.walk_act = walk_act_q;
  assign stat_o.pfx_last = &pfx_q;

  a_clr_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.clr_step && (&clr_addr_q)) |=> (clr_addr_q == '0))
    else $error("ft2_dp: clearing sweep counter did not wrap");

  a_rd_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(cmd_i.walk_step && walk_act_q))
    else $error("ft2_dp: read data valid without a walk step");

  a_sweep_no_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_step |-> !rd_vld_q)
    else $error("ft2_dp: tree read in flight during clearing sweep");

endmodule

/* hw/rtl/fenwick_tree_2d_sum.sv */
// ----------------------------------------------------------------------------
// fenwick_tree_2d_sum: 2-D binary indexed tree of wrapping sums
// Point add, rectangle sum, suffix sum and clear over a configurable grid.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive action_i and the index/value fields, raise start.
//   A request transfers on a rising edge with start high and busy low.
//   Result channel: done_o pulses for one cycle with sum_result_o and
//   status_o; the receiver cannot stall, so sample the result on that cycle.
//   Config channel: cfg_valid_i/cfg_ready_o (ready always high), index 0 is
//   rows in use, index 1 columns in use; write only while busy is low.
// Operations, with W = number of tree cells visited
// by one index walk (an add walks up to 7 rows by 7 columns at 64x64, a
// prefix walk up to 6 by 6):
//   point add       : walks W cells, one read-modify-write per cycle
//   rectangle/suffix: four prefix walks, their terms added with signs
//   clear           : 2^(row bits + col bits) entries, one entry per cycle
//   bad request     : no walk. busy drops the cycle after done_o, so the next
//   request can transfer then. One request is in flight at a time; the tree
//   memory's single read port sets the walk rate.
// Reset: a clearing sweep writes all 2^(row bits + col bits) entries (4096 at
//   64x64) and zeroes the tree; busy stays high until it finishes.
// ----------------------------------------------------------------------------
module fenwick_tree_2d_sum #(
  parameter int unsigned MAX_ROWS  = ft2_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS  = ft2_pkg::MAX_COLS_DEF,
  parameter int unsigned SUM_WIDTH = ft2_pkg::SUM_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [ft2_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [ft2_pkg::CNT_W-1:0]     cfg_data_i,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [1:0]                    action_i,
  input  logic        [ft2_pkg::IDX_W-1:0]     row_lo_i,
  input  logic        [ft2_pkg::IDX_W-1:0]     col_lo_i,
  input  logic        [ft2_pkg::IDX_W-1:0]     row_hi_i,
  input  logic        [ft2_pkg::IDX_W-1:0]     col_hi_i,
  input  logic signed [ft2_pkg::VAL_W-1:0]     add_value_i,
  // result channel
  output logic                                 done_o,
  output logic signed [ft2_pkg::RES_W-1:0]     sum_result_o,
  output logic                                 status_o
);
  import ft2_pkg::*;

  ft2_cmd_t  cmd;
  ft2_stat_t stat;

  // User must make config writes land only while idle; always accept them.
  assign cfg_ready_o = 1'b1;

  // Sequencer: walks the datapath through sweep, add and prefix phases.
  ft2_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // Datapath: registers, tree memory, index walker, accumulator.
  ft2_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .action_i     (action_i),
    .row_lo_i     (row_lo_i),
    .col_lo_i     (col_lo_i),
    .row_hi_i     (row_hi_i),
    .col_hi_i     (col_hi_i),
    .add_value_i  (add_value_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .sum_result_o (sum_result_o),
    .status_o     (status_o)
  );

endmodule

/* dv/fenwick_tree_2d_sum_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fenwick_tree_2d_sum_tb: self-checking bench for the 2-D Fenwick tree sum block
// Drives point adds, rectangle sums, suffix sums and clears through the
// start/busy request port under several grid sizes. A plain cell grid in the
// bench predicts every sum and status, and each done_o strobe is checked
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fenwick_tree_2d_sum_tb;
  import ft2_pkg::*;

  localparam int unsigned GRID_ROWS     = MAX_ROWS_DEF;
  localparam int unsigned GRID_COLS     = MAX_COLS_DEF;
  // Index with no register behind it; writes there must not disturb anything.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Limit on run length, reset sweep and clears included, beyond the slowest expected run.
  localparam int unsigned CYCLE_LIMIT   = 2_500_000;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [RES_W-1:0] sum;
    logic                    status;
  } answer_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CNT_W-1:0]        cfg_data_i;
  logic                    start;
  logic                    busy;
  logic [1:0]              action_i;
  logic [IDX_W-1:0]        row_lo_i;
  logic [IDX_W-1:0]        col_lo_i;
  logic [IDX_W-1:0]        row_hi_i;
  logic [IDX_W-1:0]        col_hi_i;
  logic signed [VAL_W-1:0] add_value_i;
  logic                    done_o;
  logic signed [RES_W-1:0] sum_result_o;
  logic                    status_o;

  fenwick_tree_2d_sum DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .row_lo_i     (row_lo_i),
    .col_lo_i     (col_lo_i),
    .row_hi_i     (row_hi_i),
    .col_hi_i     (col_hi_i),
    .add_value_i  (add_value_i),
    .done_o       (done_o),
    .sum_result_o (sum_result_o),
    .status_o     (status_o)
  );

  // --------------------------------------------------------------------------
  // Predictor state: the cell values themselves, not the tree. Any correct
  // tree returns the same wrapping rectangle totals as a direct grid sum.
  // --------------------------------------------------------------------------
  logic [RES_W-1:0] grid_q [GRID_ROWS][GRID_COLS];
  logic [CNT_W-1:0] rows_cfg;
  logic [CNT_W-1:0] cols_cfg;

  answer_t     answers_due[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          sender_idles;

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fenwick_tree_2d_sum: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Counts above the grid size act as the grid size.
  function automatic int unsigned span(logic [CNT_W-1:0] cnt, int unsigned cap);
    return (cnt > cap) ? cap : int'(cnt);
  endfunction

  function automatic void clear_grid();
    for (int r = 0; r < GRID_ROWS; r++)
      for (int c = 0; c < GRID_COLS; c++)
        grid_q[r][c] = '0;
  endfunction

  function automatic logic [RES_W-1:0] area_sum(int unsigned r1, int unsigned c1,
                                                int unsigned r2, int unsigned c2);
    logic [RES_W-1:0] acc;
    acc = '0;
    for (int unsigned r = r1; r <= r2; r++)
      for (int unsigned c = c1; c <= c2; c++)
        acc += grid_q[r][c];
    return acc;
  endfunction

  // Apply one request to the grid and return the result it must produce.
  function automatic answer_t grid_answer(action_e act, int unsigned r1, int unsigned c1,
                                          int unsigned r2, int unsigned c2,
                                          logic [VAL_W-1:0] val);
    answer_t     ans;
    int unsigned nr;
    int unsigned nc;
    nr = span(rows_cfg, GRID_ROWS);
    nc = span(cols_cfg, GRID_COLS);
    ans.sum    = '0;
    ans.status = 1'b0;
    case (act)
      ACT_ADD: begin
        if (r1 < nr && c1 < nc) grid_q[r1][c1] = grid_q[r1][c1] + val;
        else ans.status = 1'b1;
      end
      ACT_RECT: begin
        if (r1 <= r2 && c1 <= c2 && r2 < nr && c2 < nc) ans.sum = area_sum(r1, c1, r2, c2);
        else ans.status = 1'b1;
      end
      ACT_SUFFIX: begin
        // row_hi/col_hi play no part; the far corner is the last cell in use
        if (r1 < nr && c1 < nc) ans.sum = area_sum(r1, c1, nr - 1, nc - 1);
        else ans.status = 1'b1;
      end
      default: begin
        clear_grid();
      end
    endcase
    return ans;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every done_o strobe pops the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_result
    answer_t due;
    if (rst_ni && done_o) begin
      if (answers_due.size() == 0) begin
        $error("result with nothing outstanding: sum_result %0d status %0b",
               sum_result_o, status_o);
        fail_count++;
      end else begin
        due = answers_due.pop_front();
        if (sum_result_o !== due.sum) begin
          $error("sum_result: expected %0d, got %0d", due.sum, sum_result_o);
          fail_count++;
        end
        if (status_o !== due.status) begin
          $error("status: expected %0b, got %0b", due.status, status_o);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------
  // Transfer one request; the prediction is taken at the accepting edge.
  task automatic issue_request(action_e act, logic [IDX_W-1:0] r1, logic [IDX_W-1:0] c1,
                               logic [IDX_W-1:0] r2, logic [IDX_W-1:0] c2,
                               logic [VAL_W-1:0] val);
    // hold off the next request for a random burst now and then
    if (sender_idles && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    @(negedge clk_i);
    action_i    = act;
    row_lo_i    = r1;
    col_lo_i    = c1;
    row_hi_i    = r2;
    col_hi_i    = c2;
    add_value_i = val;
    start       = 1'b1;
    do @(posedge clk_i); while (busy);
    answers_due.push_back(grid_answer(act, 32'(r1), 32'(c1), 32'(r2), 32'(c2), val));
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Wait until every result is in and the block has gone quiet.
  task automatic wait_idle();
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ROWS) rows_cfg = data;
    else if (idx == CFG_COLS) cols_cfg = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_grid(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
  endtask

  // Mostly well-formed requests inside the grid in use, with some noise.
  task automatic random_request();
    int unsigned      nr;
    int unsigned      nc;
    int unsigned      pick;
    action_e          act;
    logic [IDX_W-1:0] r1;
    logic [IDX_W-1:0] c1;
    logic [IDX_W-1:0] r2;
    logic [IDX_W-1:0] c2;
    logic [VAL_W-1:0] val;
    nr = span(rows_cfg, GRID_ROWS);
    nc = span(cols_cfg, GRID_COLS);
    r1 = IDX_W'($urandom);
    c1 = IDX_W'($urandom);
    r2 = IDX_W'($urandom);
    c2 = IDX_W'($urandom);
    if (nr > 0 && nc > 0 && $urandom_range(0, 9) != 0) begin
      r1 = IDX_W'($urandom_range(0, nr - 1));
      c1 = IDX_W'($urandom_range(0, nc - 1));
      r2 = IDX_W'($urandom_range(r1, nr - 1));
      c2 = IDX_W'($urandom_range(c1, nc - 1));
    end
    case ($urandom_range(0, 7))
      0:       val = 32'h7FFF_FFFF;
      1:       val = 32'h8000_0000;
      2:       val = $urandom_range(0, 15) - 8;
      default: val = $urandom;
    endcase
    // clears cost a full sweep of the tree, so keep them rare
    pick = $urandom_range(0, 199);
    if (pick < 2) act = ACT_CLEAR;
    else if (pick < 90) act = ACT_ADD;
    else if (pick < 155) act = ACT_RECT;
    else act = ACT_SUFFIX;
    issue_request(act, r1, c1, r2, c2, val);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Full 64x64 grid: corner cells, extreme values, misordered corners, clear.
  task automatic test_corners();
    issue_request(ACT_ADD,    6'd0,  6'd0,  6'd0,  6'd0,  32'h7FFF_FFFF);
    issue_request(ACT_ADD,    6'd63, 6'd63, 6'd63, 6'd63, 32'h8000_0000);
    issue_request(ACT_ADD,    6'd0,  6'd63, 6'd21, 6'd42, 32'hFFFF_FFFF);
    issue_request(ACT_ADD,    6'd63, 6'd0,  6'd42, 6'd21, 32'h5A5A_5A5A);
    issue_request(ACT_RECT,   6'd0,  6'd0,  6'd63, 6'd63, '0);
    issue_request(ACT_RECT,   6'd63, 6'd63, 6'd63, 6'd63, '0);
    issue_request(ACT_RECT,   6'd0,  6'd0,  6'd0,  6'd0,  32'hFFFF_FFFF);
    issue_request(ACT_RECT,   6'd10, 6'd0,  6'd9,  6'd63, '0);
    issue_request(ACT_RECT,   6'd0,  6'd40, 6'd63, 6'd39, '0);
    issue_request(ACT_SUFFIX, 6'd0,  6'd0,  6'd63, 6'd63, '0);
    issue_request(ACT_SUFFIX, 6'd63, 6'd0,  6'd42, 6'd21, '0);
    issue_request(ACT_SUFFIX, 6'd1,  6'd1,  6'd0,  6'd0,  '0);
    issue_request(ACT_CLEAR,  6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF);
    issue_request(ACT_RECT,   6'd0,  6'd0,  6'd63, 6'd63, '0);
  endtask

  // Small grid: indices just past the counts in use must be refused.
  task automatic test_bounds();
    set_grid(7'd5, 7'd3);
    issue_request(ACT_ADD,    6'd5, 6'd0, 6'd0, 6'd0, 32'd1);
    issue_request(ACT_ADD,    6'd0, 6'd3, 6'd0, 6'd0, 32'd1);
    issue_request(ACT_ADD,    6'd4, 6'd2, 6'd0, 6'd0, 32'd7);
    issue_request(ACT_RECT,   6'd0, 6'd0, 6'd5, 6'd2, '0);
    issue_request(ACT_RECT,   6'd0, 6'd0, 6'd4, 6'd3, '0);
    issue_request(ACT_RECT,   6'd0, 6'd0, 6'd4, 6'd2, '0);
    issue_request(ACT_SUFFIX, 6'd4, 6'd2, 6'd63, 6'd63, '0);
  endtask

  // Zero counts refuse every add and sum; oversized counts act as the grid.
  task automatic test_count_extremes();
    set_grid(7'd0, 7'd64);
    issue_request(ACT_ADD,    6'd0, 6'd0, 6'd0, 6'd0, 32'd3);
    issue_request(ACT_RECT,   6'd0, 6'd0, 6'd0, 6'd0, '0);
    issue_request(ACT_SUFFIX, 6'd0, 6'd0, 6'd0, 6'd0, '0);
    set_grid(7'd127, 7'd127);
    write_reg(CFG_SPARE, 7'd1);
    issue_request(ACT_ADD,    6'd63, 6'd63, 6'd0, 6'd0, 32'h1234_5678);
    issue_request(ACT_SUFFIX, 6'd0,  6'd0,  6'd0, 6'd0, '0);
    set_grid(7'd64, 7'd0);
    issue_request(ACT_CLEAR,  6'd0, 6'd0, 6'd0, 6'd0, '0);
  endtask

  // Random traffic over a walk of grid sizes, extremes first.
  task automatic test_random(int unsigned phases, int unsigned per_phase);
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    for (int unsigned p = 0; p < phases; p++) begin
      case (p)
        0:       begin rows = 7'd64;  cols = 7'd64; end
        1:       begin rows = 7'd1;   cols = 7'd1;  end
        2:       begin rows = 7'd1;   cols = 7'd64; end
        3:       begin rows = 7'd64;  cols = 7'd1;  end
        4:       begin rows = 7'd127; cols = 7'd2;  end
        5:       begin rows = 7'd0;   cols = 7'd17; end
        default: begin
          rows = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(65, 127))
                                              : CNT_W'($urandom_range(1, 64));
          cols = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(65, 127))
                                              : CNT_W'($urandom_range(1, 64));
        end
      endcase
      set_grid(rows, cols);
      repeat (per_phase) random_request();
    end
  endtask

  // Drain every outstanding result between short bursts of requests.
  task automatic test_drain_pause();
    set_grid(7'd64, 7'd64);
    repeat (8) begin
      repeat (5) random_request();
      wait_idle();
    end
  endtask

  // Back-to-back requests with no sender gaps.
  task automatic test_steady(int unsigned count);
    sender_idles = 1'b0;
    set_grid(CNT_W'($urandom_range(1, 64)), CNT_W'($urandom_range(1, 64)));
    repeat (count) random_request();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_ROWS;
    cfg_data_i   = '0;
    start        = 1'b0;
    action_i     = ACT_ADD;
    row_lo_i     = '0;
    col_lo_i     = '0;
    row_hi_i     = '0;
    col_hi_i     = '0;
    add_value_i  = '0;
    fail_count   = 0;
    cycle_count  = 0;
    sender_idles = 1'b1;
    rows_cfg     = CNT_RESET;
    cols_cfg     = CNT_RESET;
    clear_grid();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // the reset clearing sweep keeps busy high for a while
    wait_idle();

    test_corners();
    test_bounds();
    test_count_extremes();
    test_random(11, 150);
    test_drain_pause();
    test_steady(200);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("fenwick_tree_2d_sum: match");
    end else begin
      $display("fenwick_tree_2d_sum: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ft2_pkg.sv
hw/rtl/ft2_ctrl.sv
hw/rtl/ft2_dp.sv
hw/rtl/fenwick_tree_2d_sum.sv
dv/fenwick_tree_2d_sum_tb.sv
